@@ rtl/lirs_pkg.sv @@
package lirs_pkg;

	// Default widths of the configurable datapath
	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int FRAC_BITS_DEF    = 16;
	localparam int COUNT_WIDTH_DEF  = 16;

	// Fixed by the register map
	localparam int STEP_WIDTH    = 24;
	localparam int STEP_RESET    = 65536;
	localparam int OUTLEN_RESET  = 2;
	localparam int MAX_INTERP    = 63;
	localparam int NCNT_WIDTH    = $clog2(MAX_INTERP + 1);
	localparam int CFG_IDX_WIDTH = 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_WIDTH-1:0] REG_STEP       = 1'b0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_OUT_LENGTH = 1'b1;

	// Microcode addresses
	localparam int UA_WIDTH = 3;
	typedef enum logic [UA_WIDTH-1:0] {
		UA_IDLE,
		UA_CHECK,
		UA_MUL,
		UA_ADV,
		UA_EMIT,
		UA_POSFIX,
		UA_FINAL
	} uaddr_t;

	// Jump conditions
	typedef enum logic [2:0] {
		JC_NEXT,
		JC_ALWAYS,
		JC_LOOP,
		JC_NO_LOOP,
		JC_NOT_LAST
	} jcond_t;

	typedef struct packed {
		logic   wait_in;
		logic   wait_out;
		logic   ld_in;
		logic   ld_diff;
		logic   ld_mul;
		logic   ld_val;
		logic   emit_interp;
		logic   fix_pos;
		logic   emit_final;
		jcond_t jcond;
		uaddr_t target;
	} ctl_word_t;

	typedef struct packed {
		logic src_valid;
		logic slot_free;
		logic loop_ok;
		logic last;
		logic have_prev;
	} stat_t;

	// Control store
	function automatic ctl_word_t ucode_word(uaddr_t addr);
		ctl_word_t w;
		w = '0;
		w.jcond  = JC_NEXT;
		w.target = UA_IDLE;
		case (addr)
			UA_IDLE: begin
				w.wait_in = 1'b1;
				w.ld_in   = 1'b1;
			end
			UA_CHECK: begin
				w.ld_diff = 1'b1;
				w.jcond   = JC_NO_LOOP;
				w.target  = UA_POSFIX;
			end
			UA_MUL: begin
				w.ld_mul = 1'b1;
			end
			UA_ADV: begin
				w.ld_val = 1'b1;
			end
			UA_EMIT: begin
				w.wait_out    = 1'b1;
				w.emit_interp = 1'b1;
				w.jcond       = JC_LOOP;
				w.target      = UA_MUL;
			end
			UA_POSFIX: begin
				w.fix_pos = 1'b1;
				w.jcond   = JC_NOT_LAST;
				w.target  = UA_IDLE;
			end
			UA_FINAL: begin
				w.wait_out   = 1'b1;
				w.emit_final = 1'b1;
				w.jcond      = JC_ALWAYS;
				w.target     = UA_IDLE;
			end
			default: begin
				w.jcond  = JC_ALWAYS;
				w.target = UA_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

@@ rtl/lirs_src_if.sv @@
interface lirs_src_if #(
	parameter int SAMPLE_WIDTH = lirs_pkg::SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] in_sample;
	logic                           in_last;

	modport source(output valid, output in_sample, output in_last, input ready);
	modport sink(input valid, input in_sample, input in_last, output ready);
endinterface

@@ rtl/lirs_dst_if.sv @@
interface lirs_dst_if #(
	parameter int SAMPLE_WIDTH = lirs_pkg::SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] out_sample;
	logic                           run_end;
	logic                           block_end;

	modport source(output valid, output out_sample, output run_end, output block_end,
		input ready);
	modport sink(input valid, input out_sample, input run_end, input block_end,
		output ready);
endinterface

@@ rtl/lirs_cfg_if.sv @@
interface lirs_cfg_if #(
	parameter int DATA_WIDTH = lirs_pkg::STEP_WIDTH
);
	logic                                   valid;
	logic                                   ready;
	logic [lirs_pkg::CFG_IDX_WIDTH-1:0]     index;
	logic [DATA_WIDTH-1:0]                  data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

@@ rtl/lirs_sequencer.sv @@
module lirs_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  lirs_pkg::stat_t     stat,
	output lirs_pkg::ctl_word_t ctl,
	output logic                go
);
	import lirs_pkg::*;

	uaddr_t upc_q;
	uaddr_t upc_d;
	logic   stall;
	logic   take;

	assign ctl   = ucode_word(upc_q);
	assign stall = (ctl.wait_in && !stat.src_valid) || (ctl.wait_out && !stat.slot_free);
	assign go    = !stall;

	always_comb begin
		case (ctl.jcond)
			JC_NEXT:     take = 1'b0;
			JC_ALWAYS:   take = 1'b1;
			JC_LOOP:     take = stat.loop_ok;
			JC_NO_LOOP:  take = !stat.loop_ok;
			JC_NOT_LAST: take = !stat.last;
			default:     take = 1'b1;
		endcase
		if (stall) begin
			upc_d = upc_q;
		end else if (take) begin
			upc_d = ctl.target;
		end else begin
			upc_d = uaddr_t'(upc_q + UA_WIDTH'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UA_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule

@@ rtl/lirs_datapath.sv @@
module lirs_datapath #(
	parameter int SAMPLE_WIDTH = lirs_pkg::SAMPLE_WIDTH_DEF,
	parameter int FRAC_BITS    = lirs_pkg::FRAC_BITS_DEF,
	parameter int COUNT_WIDTH  = lirs_pkg::COUNT_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lirs_pkg::ctl_word_t ctl,
	input  logic                go,
	output lirs_pkg::stat_t     stat,
	lirs_src_if.sink            src,
	lirs_dst_if.source          dst,
	lirs_cfg_if.sink            cfg
);
	import lirs_pkg::*;

	localparam int PW  = ((STEP_WIDTH > FRAC_BITS) ? STEP_WIDTH : FRAC_BITS + 1) + 1;
	localparam int DW  = SAMPLE_WIDTH + 1;
	localparam int PRW = DW + FRAC_BITS + 1;
	localparam int SHW = PRW - FRAC_BITS;
	localparam logic [PW-1:0]  ONE_POS  = PW'(1) << FRAC_BITS;
	localparam logic [PRW-1:0] HALF_POS = PRW'(1) << (FRAC_BITS - 1);

	// Configuration
	logic [STEP_WIDTH-1:0]  step_q;
	logic [COUNT_WIDTH-1:0] out_length_q;
	logic [COUNT_WIDTH-1:0] limit;

	// Block state
	logic signed [SAMPLE_WIDTH-1:0] prev_q;
	logic                           have_prev_q;
	logic [PW-1:0]                  pos_q;
	logic [COUNT_WIDTH-1:0]         done_q;
	logic [NCNT_WIDTH-1:0]          n_q;

	// Working registers
	logic signed [SAMPLE_WIDTH-1:0] cur_q;
	logic                           last_q;
	logic signed [DW-1:0]           diff_q;
	logic signed [PRW-1:0]          prod_s1;
	logic signed [SAMPLE_WIDTH-1:0] val_q;

	// Output register
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] out_sample_q;
	logic                           run_end_q;
	logic                           block_end_q;

	logic signed [FRAC_BITS:0] frac;
	logic signed [PRW-1:0]     rounded;
	logic signed [SHW-1:0]     shifted;
	logic signed [SHW-1:0]     interp;
	logic                      loop_ok;
	logic                      slot_free;

	assign limit = (out_length_q == '0) ? '0 : out_length_q - COUNT_WIDTH'(1);
	assign loop_ok = have_prev_q && (n_q < NCNT_WIDTH'(MAX_INTERP)) && (done_q < limit)
		&& (pos_q < ONE_POS);
	assign slot_free = !out_valid_q || dst.ready;

	assign frac    = $signed({1'b0, pos_q[FRAC_BITS-1:0]});
	assign rounded = prod_s1 + $signed(HALF_POS);
	assign shifted = SHW'(rounded >>> FRAC_BITS);
	assign interp  = SHW'(prev_q) + shifted;

	assign stat.src_valid = src.valid;
	assign stat.slot_free = slot_free;
	assign stat.loop_ok   = loop_ok;
	assign stat.last      = last_q;
	assign stat.have_prev = have_prev_q;

	assign src.ready      = ctl.wait_in;
	assign cfg.ready      = 1'b1;
	assign dst.valid      = out_valid_q;
	assign dst.out_sample = out_sample_q;
	assign dst.run_end    = run_end_q;
	assign dst.block_end  = block_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= STEP_WIDTH'(STEP_RESET);
			out_length_q <= COUNT_WIDTH'(OUTLEN_RESET);
			prev_q       <= '0;
			have_prev_q  <= 1'b0;
			pos_q        <= '0;
			done_q       <= '0;
			n_q          <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_STEP:       step_q <= cfg.data[STEP_WIDTH-1:0];
					REG_OUT_LENGTH: out_length_q <= cfg.data[COUNT_WIDTH-1:0];
					default:        ;
				endcase
			end
			if (go && (ctl.emit_interp || ctl.emit_final)) begin
				out_valid_q <= 1'b1;
			end else if (dst.ready) begin
				out_valid_q <= 1'b0;
			end
			if (go) begin
				if (ctl.ld_in) begin
					n_q <= '0;
				end
				if (ctl.ld_val) begin
					pos_q  <= pos_q + PW'(step_q);
					done_q <= done_q + COUNT_WIDTH'(1);
					n_q    <= n_q + NCNT_WIDTH'(1);
				end
				if (ctl.fix_pos) begin
					pos_q       <= (pos_q >= ONE_POS) ? pos_q - ONE_POS : '0;
					prev_q      <= cur_q;
					have_prev_q <= 1'b1;
				end
				if (ctl.emit_final) begin
					prev_q      <= '0;
					have_prev_q <= 1'b0;
					pos_q       <= '0;
					done_q      <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			if (ctl.ld_in) begin
				cur_q  <= src.in_sample;
				last_q <= src.in_last;
			end
			if (ctl.ld_diff) begin
				diff_q <= DW'(cur_q) - DW'(prev_q);
			end
			if (ctl.ld_mul) begin
				prod_s1 <= PRW'(diff_q) * PRW'(frac);
			end
			if (ctl.ld_val) begin
				val_q <= interp[SAMPLE_WIDTH-1:0];
			end
			if (ctl.emit_interp) begin
				out_sample_q <= val_q;
				run_end_q    <= !loop_ok && !last_q;
				block_end_q  <= 1'b0;
			end
			if (ctl.emit_final) begin
				out_sample_q <= cur_q;
				run_end_q    <= 1'b1;
				block_end_q  <= 1'b1;
			end
		end
	end

endmodule

@@ rtl/linear_interp_resampler_top.sv @@
// Timing: an input that makes no output retires through the check and posfix steps;
// each interpolated output takes the multiply, round and emit steps on one multiplier,
// and the final copy of a block adds the final step; up to 63 outputs per input.
// A new input waits until the last one is done; output back-pressure stalls emits.
// Reset: arst_n clears the sequencer, block state and output valid at once; step
// returns to 1.0 and out_length to 2.
module linear_interp_resampler_top #(
	parameter int SAMPLE_WIDTH = lirs_pkg::SAMPLE_WIDTH_DEF,
	parameter int FRAC_BITS    = lirs_pkg::FRAC_BITS_DEF,
	parameter int COUNT_WIDTH  = lirs_pkg::COUNT_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lirs_src_if.sink   src,
	lirs_dst_if.source dst,
	lirs_cfg_if.sink   cfg
);
	import lirs_pkg::*;

	// Control word of the current microcode step and the datapath status it branches on
	ctl_word_t ctl;
	stat_t     stat;
	logic      go;

	// Step counter and control store: walks the per-input program
	//   idle -> check -> {mul -> adv -> emit}* -> posfix -> [final]
	lirs_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl),
		.go     (go)
	);

	// Datapath: config registers, block state, one multiplier and the output register
	// that holds a finished transaction while the sequencer moves on.
	lirs_datapath #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.FRAC_BITS    (FRAC_BITS),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.go     (go),
		.stat   (stat),
		.src    (src),
		.dst    (dst),
		.cfg    (cfg)
	);

	// Input transactions are taken only by the load step
	a_in_at_load: assert property (@(posedge clk) disable iff (!arst_n)
		(src.valid && src.ready) |-> (go && ctl.ld_in))
		else $error("input accepted outside the load step");

	// Never overwrite a result that is still waiting
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(go && (ctl.emit_interp || ctl.emit_final)) |-> stat.slot_free)
		else $error("emit while output register is full");

	// Multiply only while the interpolation loop condition holds
	a_mul_loop: assert property (@(posedge clk) disable iff (!arst_n)
		(go && ctl.ld_mul) |-> stat.loop_ok)
		else $error("multiply step outside the output loop");

	// Final copy closes the block
	a_final_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(go && ctl.emit_final) |=> !stat.have_prev)
		else $error("block state not cleared after final copy");

endmodule

@@ tb/tb_linear_interp_resampler_top.sv @@
`timescale 1ns / 100ps

module tb_linear_interp_resampler_top;
	import lirs_pkg::*;

	localparam int SW = SAMPLE_WIDTH_DEF;
	localparam int FB = FRAC_BITS_DEF;
	localparam int CW = COUNT_WIDTH_DEF;

	// One source position in Q8.FB; the position register needs one bit of headroom
	// because it can pass ONE_POS by a full step before being wrapped.
	localparam logic [STEP_WIDTH:0] ONE_POS = (STEP_WIDTH + 1)'(1 << FB);
	localparam longint HALF_LSB = longint'(1) << (FB - 1);
	localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW - 1){1'b1}}};
	localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW - 1){1'b0}}};

	localparam int RANDOM_ITEMS = 480;
	// Slowest legal gap between transactions: 63 outputs, each behind a receiver stall,
	// plus a sender gap; taken several times over.
	localparam int STALL_LIMIT = 20000;
	// Cycles to let the sequencer retire an input that emits nothing, or the
	// position fix-up after its last output, before a register write.
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [SW-1:0] sample;
		logic          run_end;
		logic          block_end;
	} resampled_t;

	typedef enum logic [1:0] {
		RX_STEADY,
		RX_PATTERN,
		RX_SPARSE
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	lirs_src_if src_ch();
	lirs_dst_if dst_ch();
	lirs_cfg_if cfg_ch();

	linear_interp_resampler_top u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.src   (src_ch),
		.dst   (dst_ch),
		.cfg   (cfg_ch)
	);

	always #1 clk = ~clk;

	// Predictor copy of the rate registers and of the block state
	logic [STEP_WIDTH-1:0]   rate_step;
	logic [CW-1:0]           rate_out_length;
	logic signed [SW-1:0]    held_sample;
	logic [STEP_WIDTH:0]     out_position;
	logic [CW-1:0]           interp_count;
	logic                    primed;

	// Outputs predicted but not yet seen on the destination channel, oldest first
	resampled_t pending_outputs[$];

	int error_count     = 0;
	int samples_sent    = 0;
	int outputs_checked = 0;
	int blocks_closed   = 0;
	int reg_writes      = 0;
	int quiet_cycles    = 0;
	int burst_left      = 0;

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $time, what);
		error_count++;
	endtask

	function automatic void clear_block_state();
		held_sample  = '0;
		out_position = '0;
		interp_count = '0;
		primed       = 1'b0;
	endfunction

	// Work out every output that one source sample causes and queue it. The last
	// result of the sample is held back one slot so its run_end flag can be set.
	function automatic void predict_resample(input logic signed [SW-1:0] cur,
		input logic last);
		logic [CW-1:0] limit;
		longint        diff;
		longint        prod;
		longint        value;
		resampled_t    held;
		logic          have_held;
		int            made;

		limit     = (rate_out_length != '0) ? rate_out_length - 1'b1 : '0;
		have_held = 1'b0;
		held      = '0;
		made      = 0;
		if (primed) begin
			while (made < MAX_INTERP && interp_count < limit && out_position < ONE_POS) begin
				// Round half up: add half an LSB, then floor with an arithmetic shift
				diff  = longint'(cur) - longint'(held_sample);
				prod  = diff * longint'(out_position) + HALF_LSB;
				value = longint'(held_sample) + (prod >>> FB);
				if (have_held)
					pending_outputs.push_back(held);
				held      = '{sample: value[SW-1:0], run_end: 1'b0, block_end: 1'b0};
				have_held = 1'b1;
				made++;
				out_position = out_position + rate_step;
				interp_count = interp_count + 1'b1;
			end
			// Carry the fraction into the next interval, or restart if the step was
			// too small to leave this one
			if (out_position >= ONE_POS)
				out_position = out_position - ONE_POS;
			else
				out_position = '0;
		end
		held_sample = cur;
		primed      = 1'b1;

		if (last) begin
			if (have_held)
				pending_outputs.push_back(held);
			held      = '{sample: cur, run_end: 1'b0, block_end: 1'b1};
			have_held = 1'b1;
			clear_block_state();
		end
		if (have_held) begin
			held.run_end = 1'b1;
			pending_outputs.push_back(held);
		end
	endfunction

	function automatic logic signed [SW-1:0] rand_sample();
		return SW'($urandom);
	endfunction

	// Drop valid, wait for every predicted output, then let the sequencer settle so a
	// register write cannot land while an input is still being worked on.
	task automatic wait_idle();
		src_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write step, then out_length, as two back-to-back transactions on the
	// configuration channel. Valid stays high between them.
	task automatic program_rate(input logic [STEP_WIDTH-1:0] step_val,
		input logic [CW-1:0] len_val);
		wait_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= REG_STEP;
		cfg_ch.data  <= step_val;
		do @(posedge clk); while (!cfg_ch.ready);
		rate_step = step_val;
		cfg_ch.index <= REG_OUT_LENGTH;
		cfg_ch.data  <= STEP_WIDTH'(len_val);
		do @(posedge clk); while (!cfg_ch.ready);
		rate_out_length = len_val;
		cfg_ch.valid <= 1'b0;
		reg_writes += 2;
	endtask

	// Send one source sample. Valid is left high after the transaction so that the
	// next call can stream on; a new burst may first open a gap with valid low.
	task automatic push_sample(input logic signed [SW-1:0] smp, input logic last);
		int gap;

		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				src_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		src_ch.valid     <= 1'b1;
		src_ch.in_sample <= smp;
		src_ch.in_last   <= last;
		do @(posedge clk); while (!src_ch.ready);
		predict_resample(smp, last);
		samples_sent++;
	endtask

	task automatic send_block(input int count, input logic close);
		for (int i = 0; i < count; i++)
			push_sample(rand_sample(), close && (i == count - 1));
	endtask

	// Reset values of the registers: step 1.0, two outputs per block
	task automatic test_reset_config();
		push_sample(SAMPLE_MAX, 1'b0);
		push_sample(SAMPLE_MIN, 1'b1);
	endtask

	// First sample is also the last: only the copy comes out
	task automatic test_single_sample();
		push_sample(rand_sample(), 1'b1);
	endtask

	// Quarter step between full-scale extremes, to stress the difference and rounding
	task automatic test_full_scale_swing();
		program_rate(STEP_WIDTH'(1 << (FB - 2)), CW'(9));
		push_sample(SAMPLE_MIN, 1'b0);
		push_sample(SAMPLE_MAX, 1'b0);
		push_sample(SAMPLE_MIN, 1'b1);
	endtask

	// Count reaches its limit early; later inputs stay silent until the last one
	task automatic test_count_limit();
		program_rate(STEP_WIDTH'(ONE_POS), CW'(3));
		send_block(4, 1'b1);
	endtask

	// Block ends before out_length - 1 outputs: the missing ones are skipped
	task automatic test_short_block();
		program_rate(STEP_WIDTH'(1 << (FB - 2)), CW'(20));
		send_block(2, 1'b1);
	endtask

	// out_length of zero and of one: final copies only
	task automatic test_degenerate_length();
		program_rate(STEP_WIDTH'(ONE_POS), CW'(0));
		send_block(2, 1'b1);
		program_rate(STEP_WIDTH'(ONE_POS), CW'(1));
		send_block(2, 1'b1);
	endtask

	// Zero step: each input is capped at MAX_INTERP outputs, then the position restarts
	task automatic test_zero_step();
		program_rate('0, CW'(200));
		send_block(3, 1'b1);
	endtask

	// Largest step: the position jumps far past the next interval
	task automatic test_max_step();
		program_rate('1, CW'(4));
		send_block(3, 1'b1);
	endtask

	// Change the step between samples of one block, with the block idle
	task automatic test_config_mid_block();
		program_rate(STEP_WIDTH'(1 << (FB - 1)), CW'(30));
		send_block(2, 1'b0);
		program_rate(STEP_WIDTH'(1 << (FB - 2)), CW'(30));
		send_block(2, 1'b1);
	endtask

	// Mostly well-formed blocks whose step and out_length match their length, the
	// rest mismatched lengths, arbitrary register values, stray last flags and
	// single-sample blocks.
	task automatic test_random_blocks();
		int start_count;
		int src_len;
		int dst_len;
		int kind;
		int n;
		logic [STEP_WIDTH-1:0] step_val;
		logic [CW-1:0] len_val;

		start_count = samples_sent;
		while (samples_sent - start_count < RANDOM_ITEMS) begin
			kind    = $urandom_range(0, 9);
			src_len = $urandom_range(2, 16);
			case ($urandom_range(0, 3))
				0: dst_len = $urandom_range(2, src_len);
				1, 2: dst_len = $urandom_range(src_len, 4 * src_len);
				default: dst_len = $urandom_range(2, (src_len - 1) * 62 + 1);
			endcase
			// Software rule: step = floor((src_len - 1) / (dst_len - 1)) in Q8.FB
			step_val = STEP_WIDTH'(((src_len - 1) << FB) / (dst_len - 1));
			len_val  = CW'(dst_len);
			if (kind <= 5) begin
				program_rate(step_val, len_val);
				send_block(src_len, 1'b1);
			end else if (kind == 6) begin
				program_rate(step_val, len_val);
				send_block($urandom_range(1, src_len + 4), 1'b1);
			end else if (kind == 7) begin
				step_val = ($urandom_range(0, 1) == 0) ? STEP_WIDTH'($urandom)
					: STEP_WIDTH'($urandom_range(0, 2000));
				len_val  = ($urandom_range(0, 3) == 0) ? CW'($urandom)
					: CW'($urandom_range(0, 80));
				program_rate(step_val, len_val);
				send_block($urandom_range(1, 8), 1'b1);
			end else if (kind == 8) begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++)
					push_sample(rand_sample(), ($urandom_range(0, 3) == 0) || (i == n - 1));
			end else begin
				push_sample(rand_sample(), 1'b1);
			end
		end
	endtask

	// Receiver pacing: each window picks always-ready, a random pattern, or a sparse
	// pattern that holds ready low most of the time.
	initial begin : rx_pacing
		rx_mode_t    mode;
		logic [31:0] mask;
		int          window_left;
		int          bit_pos;

		dst_ch.ready = 1'b0;
		mode         = RX_STEADY;
		mask         = '1;
		window_left  = 0;
		bit_pos      = 0;
		forever begin
			@(posedge clk);
			if (window_left == 0) begin
				window_left = $urandom_range(16, 96);
				case ($urandom_range(0, 3))
					0: mode = RX_STEADY;
					1, 2: mode = RX_PATTERN;
					default: mode = RX_SPARSE;
				endcase
				mask = (mode == RX_SPARSE) ? ($urandom & $urandom) : $urandom;
			end
			window_left--;
			bit_pos = (bit_pos + 1) % 32;
			dst_ch.ready <= (mode == RX_STEADY) ? 1'b1 : mask[bit_pos];
		end
	end

	// Compare each output transaction with the oldest prediction
	always @(posedge clk) begin : output_check
		resampled_t want;

		if (dst_ch.valid && dst_ch.ready) begin
			if (pending_outputs.size() == 0) begin
				report_mismatch($sformatf("output %0d with nothing predicted",
					$signed(dst_ch.out_sample)));
			end else begin
				want = pending_outputs.pop_front();
				outputs_checked++;
				if (dst_ch.out_sample !== want.sample)
					report_mismatch($sformatf("out_sample %0d, predicted %0d",
						$signed(dst_ch.out_sample), $signed(want.sample)));
				if (dst_ch.run_end !== want.run_end)
					report_mismatch($sformatf("run_end %b, predicted %b",
						dst_ch.run_end, want.run_end));
				if (dst_ch.block_end !== want.block_end)
					report_mismatch($sformatf("block_end %b, predicted %b",
						dst_ch.block_end, want.block_end));
				if (want.block_end)
					blocks_closed++;
			end
		end
	end

	// Watchdog: end the run when no channel completes a transaction for too long
	always @(posedge clk) begin
		if ((src_ch.valid && src_ch.ready) || (dst_ch.valid && dst_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d outputs outstanding",
				quiet_cycles, pending_outputs.size());
			$display("linear_interp_resampler_top test failed");
			$finish;
		end
	end

	initial begin
		// Hold every input at a known value from time zero
		arst_n           = 1'b0;
		src_ch.valid     = 1'b0;
		src_ch.in_sample = '0;
		src_ch.in_last   = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = REG_STEP;
		cfg_ch.data      = '0;
		rate_step        = STEP_WIDTH'(STEP_RESET);
		rate_out_length  = CW'(OUTLEN_RESET);
		clear_block_state();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_config();
		test_single_sample();
		test_full_scale_swing();
		test_count_limit();
		test_short_block();
		test_degenerate_length();
		test_zero_step();
		test_max_step();
		test_config_mid_block();
		test_random_blocks();
		wait_idle();

		$display("Streamed %0d source samples and %0d register writes; checked %0d outputs",
			samples_sent, reg_writes, outputs_checked);
		$display("Closed %0d blocks across directed corners and random rate settings",
			blocks_closed);
		if (error_count == 0)
			$display("linear_interp_resampler_top test passed");
		else
			$display("linear_interp_resampler_top test failed");
		$finish;
	end

endmodule
